>>> src/jss_pkg.sv
`timescale 1ns / 1ps
// shared types, register codes and reset values for the jacobi stencil sweep
package jss_pkg;

    localparam int DATA_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_CNT_W = 11;

    typedef logic signed [DATA_W-1:0] t_data;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGE = 2'd0,
        CFG_ROWS = 2'd1,
        CFG_COLS = 2'd2
    } t_cfg_idx;

    localparam t_data                EDGE_RST = 24'sd25600;
    localparam logic [CFG_CNT_W-1:0] ROWS_RST = 11'd1024;
    localparam logic [CFG_CNT_W-1:0] COLS_RST = 11'd1024;

    // decoded operation of one beat, handed from control to the compute stage
    typedef struct packed {
        logic  top;
        logic  have_left;
        logic  have_right;
        logic  below_edge;
        logic  wr_one;
        logic  wr_two;
        logic  emit;
        logic  eor;
        logic  eog;
        t_data cell_val;
    } t_op;

endpackage

>>> src/jss_in_if.sv
`timescale 1ns / 1ps
// input channel: one grid cell or drain step per beat
interface jss_in_if;
    logic          valid;
    logic          ready;
    logic          mode;
    jss_pkg::t_data cell_in;

    modport source (output valid, output mode, output cell_in, input ready);
    modport sink   (input valid, input mode, input cell_in, output ready);
endinterface

>>> src/jss_out_if.sv
`timescale 1ns / 1ps
// output channel: one updated cell per beat
interface jss_out_if;
    logic          valid;
    logic          ready;
    jss_pkg::t_data cell_out;
    logic          end_of_row;
    logic          end_of_grid;

    modport source (output valid, output cell_out, output end_of_row, output end_of_grid,
                    input ready);
    modport sink   (input valid, input cell_out, input end_of_row, input end_of_grid,
                    output ready);
endinterface

>>> src/jacobi_stencil_sweep.sv
`timescale 1ns / 1ps
// top level of the jacobi four-neighbour stencil sweep
// One Jacobi sweep over a raster-order grid of signed Q16.8 cells. Every cell,
// edge cells included, becomes floor((up + down + left + right) / 4); neighbours
// outside the grid read edge_value. Output row r leaves while input row r+1
// arrives, so the first input row gives no beat; after the last input row send
// cols_in_use drain beats (mode 1) to get the last row, the final one flagged
// end_of_grid. The block takes one beat per clock unless the output stalls;
// a result goes through the synchronous read of the two line memories into
// stage one, then the adder and output register. Each line memory does one
// write and two reads per cycle, with forwarding from the beat in flight.
// Line memories hold no reset contents and need no clearing. Change
// configuration only while no beat is in flight.
module jacobi_stencil_sweep #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    jss_in_if.sink                            i_in,
    jss_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [jss_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [jss_pkg::DATA_W-1:0]        i_cfg_data
);

    localparam int COL_W = $clog2(MAX_COLS);

    jss_pkg::t_data                  r_edge;
    logic [jss_pkg::CFG_CNT_W-1:0]   r_rows;
    logic [jss_pkg::CFG_CNT_W-1:0]   r_cols;

    logic             acc;
    logic             in_ready;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] col_m1;
    logic [COL_W-1:0] col_p1;
    jss_pkg::t_op     op;
    logic             we_two;
    logic             we_one;
    logic [COL_W-1:0] wa;
    jss_pkg::t_data   wd_two;
    jss_pkg::t_data   wd_one;
    jss_pkg::t_data   two_c;
    jss_pkg::t_data   two_l;
    jss_pkg::t_data   one_c;
    jss_pkg::t_data   one_r;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge <= jss_pkg::EDGE_RST;
            r_rows <= jss_pkg::ROWS_RST;
            r_cols <= jss_pkg::COLS_RST;
        end else if (i_cfg_we) begin
            case (jss_pkg::t_cfg_idx'(i_cfg_idx))
                jss_pkg::CFG_EDGE: r_edge <= i_cfg_data;
                jss_pkg::CFG_ROWS: r_rows <= i_cfg_data[jss_pkg::CFG_CNT_W-1:0];
                jss_pkg::CFG_COLS: r_cols <= i_cfg_data[jss_pkg::CFG_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input beat
    assign acc        = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // neighbour addresses around the current column
    assign col_m1 = col - COL_W'(1);
    assign col_p1 = col + COL_W'(1);

    jss_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_mode     (i_in.mode),
        .i_cell     (i_in.cell_in),
        .i_rows_cfg (r_rows),
        .i_cols_cfg (r_cols),
        .o_col      (col),
        .o_op       (op)
    );

    // row two above the incoming one
    jss_line_mem #(
        .DEPTH (MAX_COLS)
    ) u_row_two (
        .i_clk (i_clk),
        .i_we  (we_two),
        .i_wa  (wa),
        .i_wd  (wd_two),
        .i_re  (acc),
        .i_ra0 (col),
        .i_ra1 (col_m1),
        .o_rd0 (two_c),
        .o_rd1 (two_l)
    );

    // row one above the incoming one
    jss_line_mem #(
        .DEPTH (MAX_COLS)
    ) u_row_one (
        .i_clk (i_clk),
        .i_we  (we_one),
        .i_wa  (wa),
        .i_wd  (wd_one),
        .i_re  (acc),
        .i_ra0 (col),
        .i_ra1 (col_p1),
        .o_rd0 (one_c),
        .o_rd1 (one_r)
    );

    jss_calc #(
        .MAX_COLS (MAX_COLS)
    ) u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_col       (col),
        .i_op        (op),
        .i_edge      (r_edge),
        .i_two_c     (two_c),
        .i_two_l     (two_l),
        .i_one_c     (one_c),
        .i_one_r     (one_r),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_we_two    (we_two),
        .o_we_one    (we_one),
        .o_wa        (wa),
        .o_wd_two    (wd_two),
        .o_wd_one    (wd_one),
        .o_out_valid (o_out.valid),
        .o_cell_out  (o_out.cell_out),
        .o_eor       (o_out.end_of_row),
        .o_eog       (o_out.end_of_grid)
    );

endmodule

>>> src/jss_line_mem.sv
`timescale 1ns / 1ps
// line buffer memory: one write port, two registered read ports
module jss_line_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wa,
    input  jss_pkg::t_data           i_wd,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_ra0,
    input  logic [$clog2(DEPTH)-1:0] i_ra1,
    output jss_pkg::t_data           o_rd0,
    output jss_pkg::t_data           o_rd1
);

    jss_pkg::t_data r_mem [DEPTH];
    jss_pkg::t_data r_rd0;
    jss_pkg::t_data r_rd1;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    // read ports, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd0 <= r_mem[i_ra0];
            r_rd1 <= r_mem[i_ra1];
        end
    end

    assign o_rd0 = r_rd0;
    assign o_rd1 = r_rd1;

endmodule

>>> src/jss_ctrl.sv
`timescale 1ns / 1ps
// sweep control: row, column and drain counters and per-beat decode
module jss_ctrl #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_acc,
    input  logic                                i_mode,
    input  jss_pkg::t_data                      i_cell,
    input  logic [jss_pkg::CFG_CNT_W-1:0]       i_rows_cfg,
    input  logic [jss_pkg::CFG_CNT_W-1:0]       i_cols_cfg,
    output logic [$clog2(MAX_COLS)-1:0]         o_col,
    output jss_pkg::t_op                        o_op
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CNTC_W = $clog2(MAX_COLS + 1);
    localparam int CNTR_W = $clog2(MAX_ROWS + 1);

    logic [CNTR_W-1:0] r_row_cnt;
    logic [COL_W-1:0]  r_col_cnt;
    logic [COL_W-1:0]  r_drain_cnt;

    logic [31:0]       rows_w;
    logic [31:0]       cols_w;
    logic [CNTR_W-1:0] rows_cl;
    logic [CNTC_W-1:0] cols_cl;
    logic              draining;
    logic [CNTC_W-1:0] cur_ext;
    logic [CNTC_W-1:0] c;
    logic [CNTC_W-1:0] c_p1;
    logic              last;
    logic              cell_ok;
    logic              drain_ok;
    logic              first_row;

    // clamp configured counts into 2 .. max
    always_comb begin
        rows_w = 32'(i_rows_cfg);
        cols_w = 32'(i_cols_cfg);
        if (rows_w < 32'd2) begin
            rows_w = 32'd2;
        end else if (rows_w > 32'(MAX_ROWS)) begin
            rows_w = 32'(MAX_ROWS);
        end
        if (cols_w < 32'd2) begin
            cols_w = 32'd2;
        end else if (cols_w > 32'(MAX_COLS)) begin
            cols_w = 32'(MAX_COLS);
        end
    end

    assign rows_cl = rows_w[CNTR_W-1:0];
    assign cols_cl = cols_w[CNTC_W-1:0];

    // current column, pinned to the last one if the count shrank
    assign draining  = (r_row_cnt >= rows_cl);
    assign cur_ext   = CNTC_W'(i_mode ? r_drain_cnt : r_col_cnt);
    assign c         = (cur_ext < cols_cl) ? cur_ext : cols_cl - CNTC_W'(1);
    assign c_p1      = c + CNTC_W'(1);
    assign last      = (c_p1 >= cols_cl);
    assign o_col     = c[COL_W-1:0];

    // beat decode
    assign cell_ok   = !i_mode && !draining;
    assign drain_ok  = i_mode && draining;
    assign first_row = (r_row_cnt == '0);

    always_comb begin
        o_op            = '0;
        o_op.wr_one     = cell_ok;
        o_op.wr_two     = (cell_ok && !first_row) || drain_ok;
        o_op.emit       = (cell_ok && !first_row) || drain_ok;
        o_op.top        = cell_ok && (r_row_cnt == CNTR_W'(1));
        o_op.have_left  = (c != '0);
        o_op.have_right = !last;
        o_op.below_edge = i_mode;
        o_op.eor        = o_op.emit && last;
        o_op.eog        = drain_ok && last;
        o_op.cell_val   = i_cell;
    end

    // counters advance on each accepted cell beat before draining or drain beat while draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt   <= '0;
            r_col_cnt   <= '0;
            r_drain_cnt <= '0;
        end else if (i_acc) begin
            if (cell_ok) begin
                if (last) begin
                    r_col_cnt <= '0;
                    r_row_cnt <= r_row_cnt + CNTR_W'(1);
                end else begin
                    r_col_cnt <= c_p1[COL_W-1:0];
                end
            end else if (drain_ok) begin
                if (last) begin
                    r_drain_cnt <= '0;
                    r_row_cnt   <= '0;
                    r_col_cnt   <= '0;
                end else begin
                    r_drain_cnt <= c_p1[COL_W-1:0];
                end
            end
        end
    end

`ifndef SYNTHESIS
    // the final drained cell leaves every counter at zero
    ap_eog_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && o_op.eog |=> (r_row_cnt == '0) && (r_col_cnt == '0) && (r_drain_cnt == '0))
        else $error("counters not rewound after end of grid");

    // end of grid always closes a row
    ap_eog_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_op.eog |-> o_op.eor && o_op.emit)
        else $error("end of grid without end of row");
`endif

endmodule

>>> src/jss_calc.sv
`timescale 1ns / 1ps
// compute stage: forwarding, four-neighbour average, line buffer write-back, output register
module jss_calc #(
    parameter int MAX_COLS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_acc,
    input  logic [$clog2(MAX_COLS)-1:0] i_col,
    input  jss_pkg::t_op                i_op,
    input  jss_pkg::t_data              i_edge,
    input  jss_pkg::t_data              i_two_c,
    input  jss_pkg::t_data              i_two_l,
    input  jss_pkg::t_data              i_one_c,
    input  jss_pkg::t_data              i_one_r,
    input  logic                        i_out_ready,
    output logic                        o_in_ready,
    output logic                        o_we_two,
    output logic                        o_we_one,
    output logic [$clog2(MAX_COLS)-1:0] o_wa,
    output jss_pkg::t_data              o_wd_two,
    output jss_pkg::t_data              o_wd_one,
    output logic                        o_out_valid,
    output jss_pkg::t_data              o_cell_out,
    output logic                        o_eor,
    output logic                        o_eog
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int SUM_W = jss_pkg::DATA_W + 2;

    logic             r_s1_v;
    jss_pkg::t_op     r_s1_op;
    logic [COL_W-1:0] r_s1_col;
    logic             r_fw_two_c;
    logic             r_fw_two_l;
    logic             r_fw_one_c;
    logic             r_fw_one_r;
    jss_pkg::t_data   r_fw_two_d;
    jss_pkg::t_data   r_fw_one_d;
    logic             r_out_v;
    jss_pkg::t_data   r_out_cell;
    logic             r_out_eor;
    logic             r_out_eog;

    logic              out_free;
    logic              s1_fire;
    jss_pkg::t_data    center;
    jss_pkg::t_data    right_mem;
    jss_pkg::t_data    up;
    jss_pkg::t_data    left;
    jss_pkg::t_data    right;
    jss_pkg::t_data    below;
    logic signed [SUM_W-1:0] sum;

    // handshake: stage one moves when its result has a place to go
    assign out_free   = !r_out_v || i_out_ready;
    assign s1_fire    = r_s1_v && (!r_s1_op.emit || out_free);
    assign o_in_ready = !r_s1_v || s1_fire;

    // memory data with forwarding from the write of the beat before
    assign center    = r_fw_one_c ? r_fw_one_d : i_one_c;
    assign right_mem = r_fw_one_r ? r_fw_one_d : i_one_r;

    // neighbour selection, outside the grid reads the edge value
    always_comb begin
        up    = r_s1_op.top ? i_edge : (r_fw_two_c ? r_fw_two_d : i_two_c);
        left  = r_s1_op.have_left ? (r_fw_two_l ? r_fw_two_d : i_two_l) : i_edge;
        right = r_s1_op.have_right ? right_mem : i_edge;
        below = r_s1_op.below_edge ? i_edge : r_s1_op.cell_val;
    end

    // wide sum, floor of a quarter by arithmetic shift
    assign sum = SUM_W'(up) + SUM_W'(below) + SUM_W'(left) + SUM_W'(right);

    // line buffer write-back: row shifts down, new cell enters
    assign o_we_two = s1_fire && r_s1_op.wr_two;
    assign o_we_one = s1_fire && r_s1_op.wr_one;
    assign o_wa     = r_s1_col;
    assign o_wd_two = center;
    assign o_wd_one = r_s1_op.cell_val;

    // stage one register and forwarding flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_acc) begin
            r_s1_v <= 1'b1;
        end else if (s1_fire) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_op    <= i_op;
            r_s1_col   <= i_col;
            r_fw_two_c <= o_we_two && (r_s1_col == i_col);
            r_fw_two_l <= o_we_two && (r_s1_col == i_col - COL_W'(1));
            r_fw_one_c <= o_we_one && (r_s1_col == i_col);
            r_fw_one_r <= o_we_one && (r_s1_col == i_col + COL_W'(1));
            r_fw_two_d <= center;
            r_fw_one_d <= r_s1_op.cell_val;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_fire && r_s1_op.emit) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_op.emit) begin
            r_out_cell <= sum[SUM_W-1:2];
            r_out_eor  <= r_s1_op.eor;
            r_out_eog  <= r_s1_op.eog;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_cell_out  = r_out_cell;
    assign o_eor       = r_out_eor;
    assign o_eog       = r_out_eog;

`ifndef SYNTHESIS
    // a result held back by a full output stays in stage one
    ap_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && r_s1_op.emit && r_out_v && !i_out_ready |=> r_s1_v)
        else $error("stage one dropped a stalled result");

    // a new beat never lands on an item that is still waiting
    ap_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc |-> !r_s1_v || s1_fire)
        else $error("stage one overwritten");

    // output comes up only from a result-bearing beat
    ap_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(r_s1_v && r_s1_op.emit))
        else $error("output valid without a source beat");
`endif

endmodule
